>>> sv/fdstep_pkg.sv
// ---------------------------------------------------------------------------
// Finite-difference step size: shared types and constants
// Widths, fixed-point scaling, register indexes and request structs.
// ---------------------------------------------------------------------------
package fdstep_pkg;

  // element format
  localparam int ELEM_W    = 32;
  localparam int ELEM_FRAC = 16;

  // configuration formats
  localparam int RATIO_W   = 48;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 2;

  // accumulators and result
  localparam int ACC_W     = 64;
  localparam int STEP_W    = 64;
  localparam int STEP_FRAC = 32;

  // shared multiplier: one 32-bit limb pair per pass, signed 33x33
  localparam int LIMB_W  = 32;
  localparam int MUL_W   = LIMB_W + 1;
  localparam int XLIMBS  = 3;
  localparam int YLIMBS  = 2;
  localparam int X_W     = XLIMBS * LIMB_W;
  localparam int Y_W     = YLIMBS * LIMB_W;
  localparam int WIDE_W  = X_W + Y_W;
  localparam int NPAIRS  = XLIMBS * YLIMBS;
  localparam int CMP_W   = 2 * ACC_W;

  // scaling shifts
  localparam int CLAMP_SHIFT = RATIO_W - ELEM_FRAC;
  localparam int QUOT_SHIFT  = RATIO_W - STEP_FRAC;
  localparam int DIV_HI_LSB  = QUOT_SHIFT + STEP_W - 1;
  localparam int DIV_STEPS   = STEP_W - 1;

  localparam int CNT_W = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATIO      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE_ERROR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOMP_PERIOD  = 2'd2;

  // reset values
  localparam logic [RATIO_W-1:0]  MIN_RATIO_RST = 48'd281474977;
  localparam logic [RATIO_W-1:0]  REL_ERR_RST   = 48'd4194304;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] point_value;
    logic signed [ELEM_W-1:0] direction_value;
    logic                     last_element;
  } in_req_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step_size;
    logic                     zero_direction;
    logic                     was_recomputed;
    logic                     saturated;
  } out_req_t;

endpackage

>>> sv/finite_difference_step_size.sv
// ---------------------------------------------------------------------------
// Finite-difference step size
// Accumulates dot product, one-norm and squared two-norm of a streamed
// vector pair and on the last element returns the differencing step h.
// ---------------------------------------------------------------------------
// Sequence: each element is accepted, then takes two passes through the shared
//   multiplier and the accumulate pass. A last element then returns the held
//   or zero step, or recomputes h.
// Throughput: one request at a time; set by the single 33x33 multiplier and
//   the one-bit-per-cycle divider (16 steps for the period check, 63 for h).
// Reset: asynchronous, clears accumulators, vector counter, held step and
//   loads the configuration defaults. No clearing pass is needed.
// ---------------------------------------------------------------------------
module finite_difference_step_size
  import fdstep_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // element requests
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_req_t              in_req_i,
  // step requests
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_req_t             out_req_o,
  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RATIO_W-1:0]   cfg_data_i
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_MUL_PD    = 13'b0000000000010,
    S_MUL_DD    = 13'b0000000000100,
    S_ACC_DD    = 13'b0000000001000,
    S_MOD_STEP  = 13'b0000000010000,
    S_DECIDE    = 13'b0000000100000,
    S_LMUL      = 13'b0000001000000,
    S_LADD      = 13'b0000010000000,
    S_CLAMP     = 13'b0000100000000,
    S_DIV_CHECK = 13'b0001000000000,
    S_DIV_STEP  = 13'b0010000000000,
    S_FINISH    = 13'b0100000000000
  } state_e;

  // control state
  state_e              state_q, state_d;
  logic [RATIO_W-1:0]  min_ratio_q, min_ratio_d;
  logic [RATIO_W-1:0]  rel_err_q, rel_err_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [ACC_W-1:0]    dot_q, dot_d;
  logic [ACC_W-1:0]    abs_sum_q, abs_sum_d;
  logic [ACC_W-1:0]    sq_sum_q, sq_sum_d;
  logic                ovf_q, ovf_d;
  logic [PERIOD_W-1:0] vec_cnt_q, vec_cnt_d;
  logic [STEP_W-1:0]   held_q, held_d;
  logic                out_valid_q, out_valid_d;

  // datapath
  logic [ELEM_W-1:0]   elem_p_q, elem_p_d;
  logic [ELEM_W-1:0]   elem_d_q, elem_d_d;
  logic                last_q, last_d;
  logic [ACC_W-1:0]    prod_q, prod_d;
  logic [X_W-1:0]      x_q, x_d;
  logic [Y_W-1:0]      y_q, y_d;
  logic [WIDE_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                phase_num_q, phase_num_d;
  logic [STEP_W-1:0]   rem_q, rem_d;
  logic [STEP_W-1:0]   quo_q, quo_d;
  logic [STEP_W-1:0]   div_q, div_d;
  logic                neg_q, neg_d;
  logic                sat_q, sat_d;
  logic                held_sel_q, held_sel_d;
  logic                zero_sel_q, zero_sel_d;
  out_req_t            out_q, out_d;

  // ---------------------------------------------------------------------
  // Shared multiplier: element products or one limb pair per pass
  // ---------------------------------------------------------------------
  logic [LIMB_W-1:0]        x_limb, y_limb;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [MUL_W-1:0]  p_ext, d_ext;

  assign p_ext = {{(MUL_W-ELEM_W){elem_p_q[ELEM_W-1]}}, elem_p_q};
  assign d_ext = {{(MUL_W-ELEM_W){elem_d_q[ELEM_W-1]}}, elem_d_q};

  always_comb begin
    case (cnt_q[2:1])
      2'd0:    x_limb = x_q[LIMB_W-1:0];
      2'd1:    x_limb = x_q[2*LIMB_W-1:LIMB_W];
      default: x_limb = x_q[3*LIMB_W-1:2*LIMB_W];
    endcase
    y_limb = cnt_q[0] ? y_q[2*LIMB_W-1:LIMB_W] : y_q[LIMB_W-1:0];
  end

  always_comb begin
    case (state_q)
      S_MUL_PD: begin
        mul_a = p_ext;
        mul_b = d_ext;
      end
      S_MUL_DD: begin
        mul_a = d_ext;
        mul_b = d_ext;
      end
      default: begin
        mul_a = $signed({1'b0, x_limb});
        mul_b = $signed({1'b0, y_limb});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------
  // Saturating accumulators
  // ---------------------------------------------------------------------
  logic [ACC_W:0]      dot_sum, abs_add, sq_add;
  logic [ELEM_W-1:0]   d_abs;
  logic                dot_ovf;

  assign dot_sum = {dot_q[ACC_W-1], dot_q} + {prod_q[ACC_W-1], prod_q};
  assign dot_ovf = dot_sum[ACC_W] != dot_sum[ACC_W-1];
  assign d_abs   = elem_d_q[ELEM_W-1] ? (~elem_d_q + 1'b1) : elem_d_q;
  assign abs_add = {1'b0, abs_sum_q} + {{(ACC_W-ELEM_W+1){1'b0}}, d_abs};
  assign sq_add  = {1'b0, sq_sum_q} + {1'b0, prod_q};

  // ---------------------------------------------------------------------
  // Wide product accumulation: add limb product at its column
  // ---------------------------------------------------------------------
  logic [1:0]        col;
  logic [WIDE_W-1:0] prod_wide, addend;

  assign col       = cnt_q[2:1] + {1'b0, cnt_q[0]};
  assign prod_wide = {{(WIDE_W-ACC_W){1'b0}}, prod_q};

  always_comb begin
    case (col)
      2'd0:    addend = prod_wide;
      2'd1:    addend = prod_wide << LIMB_W;
      2'd2:    addend = prod_wide << (2*LIMB_W);
      default: addend = prod_wide << (3*LIMB_W);
    endcase
  end

  // ---------------------------------------------------------------------
  // Clamp: compare |dot| against min_ratio * one-norm at common scale
  // ---------------------------------------------------------------------
  logic [ACC_W-1:0] mag;
  logic [CMP_W-1:0] lhs, thr, m_sel;

  assign mag   = dot_q[ACC_W-1] ? (ACC_W'(0) - dot_q) : dot_q;
  assign lhs   = {{(CMP_W-ACC_W){1'b0}}, mag} << CLAMP_SHIFT;
  assign thr   = acc_q[CMP_W-1:0];
  assign m_sel = (lhs < thr) ? (thr >> CLAMP_SHIFT) : {{(CMP_W-ACC_W){1'b0}}, mag};

  // ---------------------------------------------------------------------
  // Shared restoring divider step: one quotient bit per cycle
  // ---------------------------------------------------------------------
  logic [STEP_W:0]   shifted;
  logic [STEP_W+1:0] diff;
  logic              ge;
  logic [STEP_W-1:0] rem_step, quo_step;

  assign shifted  = {rem_q, quo_q[STEP_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, div_q};
  assign ge       = !diff[STEP_W+1];
  assign rem_step = ge ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
  assign quo_step = {quo_q[STEP_W-2:0], ge};

  // quotient high part decides saturation before the 63 division steps
  localparam int HI_W = WIDE_W - DIV_HI_LSB;
  logic [HI_W-1:0]     num_hi;
  logic                quo_sat;
  logic [PERIOD_W-1:0] period_eff;

  assign num_hi     = acc_q[WIDE_W-1:DIV_HI_LSB];
  assign quo_sat    = num_hi >= {{(HI_W-ACC_W){1'b0}}, sq_sum_q};
  assign period_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;

  // ---------------------------------------------------------------------
  // Final step value
  // ---------------------------------------------------------------------
  logic [STEP_W-1:0] q_mag, step_new;
  logic              out_free;

  assign q_mag    = sat_q ? {1'b0, {(STEP_W-1){1'b1}}} : {1'b0, quo_q[STEP_W-2:0]};
  assign step_new = neg_q ? (STEP_W'(0) - q_mag) : q_mag;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    min_ratio_d = min_ratio_q;
    rel_err_d   = rel_err_q;
    period_d    = period_q;
    dot_d       = dot_q;
    abs_sum_d   = abs_sum_q;
    sq_sum_d    = sq_sum_q;
    ovf_d       = ovf_q;
    vec_cnt_d   = vec_cnt_q;
    held_d      = held_q;
    out_valid_d = out_valid_q && out_stall_i;
    elem_p_d    = elem_p_q;
    elem_d_d    = elem_d_q;
    last_d      = last_q;
    prod_d      = prod_q;
    x_d         = x_q;
    y_d         = y_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    phase_num_d = phase_num_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    div_d       = div_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    held_sel_d  = held_sel_q;
    zero_sel_d  = zero_sel_q;
    out_d       = out_q;

    // configuration writes must arrive only while idle; the block does not enforce it
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_RATIO:      min_ratio_d = cfg_data_i;
        CFG_RELATIVE_ERROR: rel_err_d   = cfg_data_i;
        CFG_RECOMP_PERIOD:  period_d    = cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        // take the next element pair
        if (in_valid_i) begin
          elem_p_d = in_req_i.point_value;
          elem_d_d = in_req_i.direction_value;
          last_d   = in_req_i.last_element;
          state_d  = S_MUL_PD;
        end
      end
      S_MUL_PD: begin
        prod_d  = mul_p[ACC_W-1:0];
        state_d = S_MUL_DD;
      end
      S_MUL_DD: begin
        // fold point*direction while the multiplier squares the direction
        if (dot_ovf) begin
          dot_d = dot_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
          ovf_d = 1'b1;
        end else begin
          dot_d = dot_sum[ACC_W-1:0];
        end
        prod_d  = mul_p[ACC_W-1:0];
        state_d = S_MUL_DD == state_q ? S_ACC_DD : state_q;
      end
      S_ACC_DD: begin
        if (abs_add[ACC_W]) begin
          abs_sum_d = '1;
          ovf_d     = 1'b1;
        end else begin
          abs_sum_d = abs_add[ACC_W-1:0];
        end
        if (sq_add[ACC_W]) begin
          sq_sum_d = '1;
          ovf_d    = 1'b1;
        end else begin
          sq_sum_d = sq_add[ACC_W-1:0];
        end
        if (last_q) begin
          // vector_counter mod period through the divider
          rem_d   = '0;
          quo_d   = {vec_cnt_q, {(STEP_W-PERIOD_W){1'b0}}};
          div_d   = {{(STEP_W-PERIOD_W){1'b0}}, period_eff};
          cnt_d   = CNT_W'(PERIOD_W - 1);
          state_d = S_MOD_STEP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_MOD_STEP: begin
        rem_d = rem_step;
        quo_d = quo_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        held_sel_d = rem_q[PERIOD_W-1:0] != '0;
        zero_sel_d = (rem_q[PERIOD_W-1:0] == '0) && (sq_sum_q == '0);
        sat_d      = 1'b0;
        neg_d      = dot_q[ACC_W-1];
        if ((rem_q[PERIOD_W-1:0] != '0) || (sq_sum_q == '0)) begin
          state_d = S_FINISH;
        end else begin
          // threshold = min_ratio * one-norm
          x_d         = {{(X_W-ACC_W){1'b0}}, abs_sum_q};
          y_d         = {{(Y_W-RATIO_W){1'b0}}, min_ratio_q};
          acc_d       = '0;
          cnt_d       = '0;
          phase_num_d = 1'b0;
          state_d     = S_LMUL;
        end
      end
      S_LMUL: begin
        prod_d  = mul_p[ACC_W-1:0];
        state_d = S_LADD;
      end
      S_LADD: begin
        acc_d = acc_q + addend;
        if (cnt_q == CNT_W'(NPAIRS - 1)) begin
          state_d = phase_num_q ? S_DIV_CHECK : S_CLAMP;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_LMUL;
        end
      end
      S_CLAMP: begin
        // numerator = relative_error * (clamped) |dot|
        x_d         = m_sel[X_W-1:0];
        y_d         = {{(Y_W-RATIO_W){1'b0}}, rel_err_q};
        acc_d       = '0;
        cnt_d       = '0;
        phase_num_d = 1'b1;
        state_d     = S_LMUL;
      end
      S_DIV_CHECK: begin
        if (quo_sat) begin
          sat_d   = 1'b1;
          state_d = S_FINISH;
        end else begin
          rem_d   = num_hi[STEP_W-1:0];
          quo_d   = {acc_q[DIV_HI_LSB-1:QUOT_SHIFT], 1'b0};
          div_d   = sq_sum_q;
          cnt_d   = CNT_W'(DIV_STEPS - 1);
          state_d = S_DIV_STEP;
        end
      end
      S_DIV_STEP: begin
        rem_d = rem_step;
        quo_d = quo_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free, then drop the vector
        if (out_free) begin
          out_valid_d = 1'b1;
          if (held_sel_q) begin
            out_d.step_size      = held_q;
            out_d.zero_direction = 1'b0;
            out_d.was_recomputed = 1'b0;
            out_d.saturated      = 1'b0;
            vec_cnt_d            = vec_cnt_q + 1'b1;
          end else if (zero_sel_q) begin
            out_d.step_size      = '0;
            out_d.zero_direction = 1'b1;
            out_d.was_recomputed = 1'b1;
            out_d.saturated      = ovf_q;
          end else begin
            out_d.step_size      = step_new;
            out_d.zero_direction = 1'b0;
            out_d.was_recomputed = 1'b1;
            out_d.saturated      = sat_q || ovf_q;
            held_d               = step_new;
            vec_cnt_d            = vec_cnt_q + 1'b1;
          end
          dot_d     = '0;
          abs_sum_d = '0;
          sq_sum_d  = '0;
          ovf_d     = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_ratio_q <= MIN_RATIO_RST;
      rel_err_q   <= REL_ERR_RST;
      period_q    <= PERIOD_RST;
      dot_q       <= '0;
      abs_sum_q   <= '0;
      sq_sum_q    <= '0;
      ovf_q       <= 1'b0;
      vec_cnt_q   <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      min_ratio_q <= min_ratio_d;
      rel_err_q   <= rel_err_d;
      period_q    <= period_d;
      dot_q       <= dot_d;
      abs_sum_q   <= abs_sum_d;
      sq_sum_q    <= sq_sum_d;
      ovf_q       <= ovf_d;
      vec_cnt_q   <= vec_cnt_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_p_q    <= elem_p_d;
    elem_d_q    <= elem_d_d;
    last_q      <= last_d;
    prod_q      <= prod_d;
    x_q         <= x_d;
    y_q         <= y_d;
    acc_q       <= acc_d;
    cnt_q       <= cnt_d;
    phase_num_q <= phase_num_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    div_q       <= div_d;
    neg_q       <= neg_d;
    sat_q       <= sat_d;
    held_sel_q  <= held_sel_d;
    zero_sel_q  <= zero_sel_d;
    out_q       <= out_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule
